### hw/rtl/hmesh_pkg.sv
package hmesh_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;

	localparam int GRID_W   = 11;
	localparam int CNT_W    = 10;
	localparam int COEF_W   = 16;
	localparam int PIX_W    = 8;
	localparam int POS_W    = 28;
	localparam int HGT_W    = 16;
	localparam int COLOR_W  = 8;
	localparam int IDX_W    = 20;
	localparam int DATA_W   = 120;
	localparam int USER_W   = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SPACING = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 8'd3;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_INDEX  = 1'b1;

	localparam logic [GRID_W-1:0] GRID_MIN       = 11'd2;
	localparam logic [GRID_W-1:0] GRID_COLS_MAX  = GRID_W'(MAX_COLUMNS);
	localparam logic [GRID_W-1:0] GRID_ROWS_MAX  = GRID_W'(MAX_ROWS);

	// ceil(2^32/255) and ceil(2^23/255): exact floor(x/255) for 24-bit and 16-bit x
	localparam logic [24:0] RECIP255_32 = 25'd16843010;
	localparam logic [15:0] RECIP255_23 = 16'd32897;

	localparam logic [7:0] RED_BASE   = 8'd26;
	localparam logic [7:0] GREEN_BASE = 8'd77;
	localparam logic [7:0] BLUE_BASE  = 8'd26;
	localparam logic [7:0] RED_GAIN   = 8'd64;
	localparam logic [7:0] GREEN_GAIN = 8'd140;
	localparam logic [7:0] BLUE_GAIN  = 8'd51;

	function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] v,
			input logic [GRID_W-1:0] hi);
		logic [GRID_W-1:0] r;
		if (v < GRID_MIN) begin
			r = GRID_MIN;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [HGT_W-1:0] div255_24(input logic [23:0] x);
		logic [48:0] prod;
		prod = 49'(x) * 49'(RECIP255_32);
		return prod[47:32];
	endfunction

	// base + floor(p*gain/255), gain is always a constant at the call site
	function automatic logic [COLOR_W-1:0] color_ramp(input logic [PIX_W-1:0] p,
			input logic [7:0] gain, input logic [7:0] base);
		logic [15:0] y;
		logic [31:0] prod;
		y = 16'(p) * 16'(gain);
		prod = 32'(y) * 32'(RECIP255_23);
		return prod[30:23] + base;
	endfunction

endpackage

### hw/rtl/heightmap_terrain_mesh_generator_unit.sv
// Height-map to triangle-mesh stream. Pixels enter row-major on s_axis; each yields
// one vertex word, and a pixel with col>0 and row>0 also yields the six index words
// of the quad it closes (order i0,i2,i1,i1,i2,i3). A pixel is accepted every cycle
// while it makes a single word and m_axis_tready is high; a quad-closing pixel holds
// the single result port until all seven of its words are out, and the pixels behind
// it wait. A pixel's first word goes through the input reg, product stage, record
// stage and output reg in that order. Writing grid_columns or grid_rows restarts the
// frame at pixel 0.
// Config writes are always taken and must only be issued while the block is idle.
module heightmap_terrain_mesh_generator_unit import hmesh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] pixel_height
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [27:0] pos_x, [43:28] pos_height, [71:44] pos_z, [79:72] color_red,
	// [87:80] color_green, [95:88] color_blue, [115:96] vertex_index, [119:116] zero
	output logic [DATA_W-1:0]     m_axis_tdata,
	output logic [USER_W-1:0]     m_axis_tuser,  // [0] result_kind, [1] frame_end
	output logic                  m_axis_tlast   // last_of_item
);

	typedef enum logic [2:0] {
		STEP_VERTEX, STEP_I0, STEP_I2A, STEP_I1A, STEP_I1B, STEP_I2B, STEP_I3
	} step_t;

	// config and frame position
	logic [GRID_W-1:0] grid_columns_q, grid_rows_q;
	logic [COEF_W-1:0] cell_spacing_q, height_scale_q;
	logic [CNT_W-1:0]  col_q, row_q;
	logic [GRID_W-1:0] w, h;
	logic [CNT_W-1:0]  w_m1, h_m1;

	// stage 1: input register
	logic              valid_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [CNT_W-1:0]  col_s1, row_s1;
	logic              quad_s1, last_s1;

	// stage 2: products
	logic              valid_s2;
	logic [23:0]       hprod_s2;
	logic [POS_W-1:0]  x_s2, z_s2;
	logic [COLOR_W-1:0] red_s2, green_s2, blue_s2;
	logic [IDX_W-1:0]  rw_s2;
	logic [CNT_W-1:0]  col_s2;
	logic              quad_s2, last_s2;

	// stage 3: record, stepped out one word per cycle while the output register can load
	logic              valid_s3;
	step_t             step_s3;
	logic [HGT_W-1:0]  hgt_s3;
	logic [POS_W-1:0]  x_s3, z_s3;
	logic [COLOR_W-1:0] red_s3, green_s3, blue_s3;
	logic [IDX_W-1:0]  vidx_s3, i0_s3, i1_s3, i2_s3;
	logic              quad_s3, last_s3;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [USER_W-1:0] out_user_q;
	logic              out_last_q;

	logic in_acc, s1_adv, s2_adv, s3_adv, out_load, step_final;
	logic signed [11:0] dx, dz;
	logic signed [28:0] xprod, zprod;
	logic [IDX_W-1:0]   vidx_n, i2_n, i0_n;
	logic [IDX_W-1:0]   sel_idx;
	logic               sel_kind;
	logic [DATA_W-1:0]  sel_data;
	step_t              step_next;

	assign cfg_ready = 1'b1;
	assign w    = clamp_grid(grid_columns_q, GRID_COLS_MAX);
	assign h    = clamp_grid(grid_rows_q, GRID_ROWS_MAX);
	assign w_m1 = CNT_W'(w - 11'd1);
	assign h_m1 = CNT_W'(h - 11'd1);

	assign step_final = quad_s3 ? (step_s3 == STEP_I3) : (step_s3 == STEP_VERTEX);
	assign out_load   = valid_s3 && (!out_valid_q || m_axis_tready);
	assign s3_adv     = out_load && step_final;
	assign s2_adv     = valid_s2 && (!valid_s3 || s3_adv);
	assign s1_adv     = valid_s1 && (!valid_s2 || s2_adv);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_acc     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= 11'd64;
			grid_rows_q    <= 11'd48;
			cell_spacing_q <= 16'd256;
			height_scale_q <= 16'd256;
			col_q          <= '0;
			row_q          <= '0;
		end else begin
			if (in_acc) begin
				if (col_q == w_m1) begin
					col_q <= '0;
					row_q <= (row_q == h_m1) ? '0 : row_q + 10'd1;
				end else begin
					col_q <= col_q + 10'd1;
				end
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_GRID_COLUMNS: begin
						grid_columns_q <= cfg_data[GRID_W-1:0];
						col_q <= '0;
						row_q <= '0;
					end
					REG_GRID_ROWS: begin
						grid_rows_q <= cfg_data[GRID_W-1:0];
						col_q <= '0;
						row_q <= '0;
					end
					REG_CELL_SPACING: cell_spacing_q <= cfg_data;
					REG_HEIGHT_SCALE: height_scale_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= s_axis_tdata[PIX_W-1:0];
			col_s1  <= col_q;
			row_s1  <= row_q;
			quad_s1 <= (col_q != '0) && (row_q != '0);
			last_s1 <= (col_q == w_m1) && (row_q == h_m1);
		end
	end

	// stage 2: centred offsets in half-spacing units, then one multiply each
	assign dx    = $signed({1'b0, col_s1, 1'b0}) - $signed({1'b0, w_m1});
	assign dz    = $signed({1'b0, row_s1, 1'b0}) - $signed({1'b0, h_m1});
	assign xprod = dx * $signed({1'b0, cell_spacing_q});
	assign zprod = dz * $signed({1'b0, cell_spacing_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || s2_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			hprod_s2 <= 24'(pix_s1) * 24'(height_scale_q);
			x_s2     <= xprod[POS_W-1:0];
			z_s2     <= zprod[POS_W-1:0];
			red_s2   <= color_ramp(pix_s1, RED_GAIN, RED_BASE);
			green_s2 <= color_ramp(pix_s1, GREEN_GAIN, GREEN_BASE);
			blue_s2  <= color_ramp(pix_s1, BLUE_GAIN, BLUE_BASE);
			rw_s2    <= IDX_W'(row_s1) * IDX_W'(w);
			col_s2   <= col_s1;
			quad_s2  <= quad_s1;
			last_s2  <= last_s1;
		end
	end

	// stage 3: quad corners from the vertex index (i3 is the vertex itself)
	assign vidx_n = rw_s2 + IDX_W'(col_s2);
	assign i2_n   = vidx_n - 20'd1;
	assign i0_n   = i2_n - IDX_W'(w);

	always_comb begin
		case (step_s3)
			STEP_VERTEX: step_next = STEP_I0;
			STEP_I0:     step_next = STEP_I2A;
			STEP_I2A:    step_next = STEP_I1A;
			STEP_I1A:    step_next = STEP_I1B;
			STEP_I1B:    step_next = STEP_I2B;
			STEP_I2B:    step_next = STEP_I3;
			default:     step_next = STEP_VERTEX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			step_s3  <= STEP_VERTEX;
		end else if (s2_adv || s3_adv) begin
			valid_s3 <= s2_adv;
			step_s3  <= STEP_VERTEX;
		end else if (out_load) begin
			step_s3  <= step_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			hgt_s3   <= div255_24(hprod_s2);
			x_s3     <= x_s2;
			z_s3     <= z_s2;
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			vidx_s3  <= vidx_n;
			i2_s3    <= i2_n;
			i0_s3    <= i0_n;
			i1_s3    <= i0_n + 20'd1;
			quad_s3  <= quad_s2;
			last_s3  <= last_s2;
		end
	end

	// word select
	always_comb begin
		sel_kind = KIND_INDEX;
		case (step_s3)
			STEP_VERTEX: begin
				sel_idx  = vidx_s3;
				sel_kind = KIND_VERTEX;
			end
			STEP_I0:     sel_idx = i0_s3;
			STEP_I2A:    sel_idx = i2_s3;
			STEP_I1A:    sel_idx = i1_s3;
			STEP_I1B:    sel_idx = i1_s3;
			STEP_I2B:    sel_idx = i2_s3;
			STEP_I3:     sel_idx = vidx_s3;
			default:     sel_idx = vidx_s3;
		endcase
		if (sel_kind == KIND_VERTEX) begin
			sel_data = {4'd0, sel_idx, blue_s3, green_s3, red_s3, z_s3, hgt_s3, x_s3};
		end else begin
			sel_data = {4'd0, sel_idx, 96'd0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= sel_data;
			out_user_q <= {step_final && last_s3, sel_kind};
			out_last_q <= step_final;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule
